[sv/tcw_pkg.sv]
package tcw_pkg;

    localparam int IDX_W  = 11;
    localparam int CODE_W = 9;
    localparam int BYTE_W = 8;
    localparam int CELL_W = 16;

    localparam logic                MODE_READ  = 1'b1;
    localparam logic [CODE_W-1:0]   CODE_BS    = 9'h100;
    localparam logic [CODE_W-1:0]   CODE_NL    = 9'h00A;
    localparam logic [BYTE_W-1:0]   ECHO_BS    = 8'h08;
    localparam logic [BYTE_W-1:0]   ECHO_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0]   ECHO_NL    = 8'h0A;
    localparam logic [BYTE_W-1:0]   ATTR_RESET = 8'h07;
    localparam logic [1:0]          STEP_SPACE = 2'd1;
    localparam logic [1:0]          STEP_LAST  = 2'd2;

    typedef enum logic [1:0] {
        OP_CHAR,
        OP_NEWLINE,
        OP_BACKSPACE,
        OP_READ
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [BYTE_W-1:0]  data;
        logic [IDX_W-1:0]   read_index;
        logic               in_range;
    } t_cmd;

    typedef struct packed {
        logic take;
        logic clearing;
    } t_back_status;

    typedef struct packed {
        logic [BYTE_W-1:0]  uart_byte;
        logic               uart_valid;
        logic [IDX_W-1:0]   cursor_position;
        logic [CELL_W-1:0]  cell_value;
        logic               last;
    } t_result;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_DRAIN,
        ST_WIPE,
        ST_EMIT
    } t_state;

endpackage

[sv/tcw_front.sv]
module tcw_front
    import tcw_pkg::*;
#(
    parameter int CELLS = 1920
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic                i_mode,
    input  logic [CODE_W-1:0]   i_char_code,
    input  logic [IDX_W-1:0]    i_read_index,
    output logic                o_cmd_valid,
    output t_cmd                o_cmd,
    input  t_back_status        i_status
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);

    t_cmd            r_q [DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [NW-1:0]   r_cnt;
    t_cmd            cmd_in;
    logic            accept;
    logic            take;

    // classify the incoming item
    always_comb begin
        cmd_in.data       = i_char_code[BYTE_W-1:0];
        cmd_in.read_index = i_read_index;
        cmd_in.in_range   = (32'(i_read_index) < 32'(CELLS));
        priority if (i_mode == MODE_READ) begin
            cmd_in.op = OP_READ;
        end else if (i_char_code == CODE_BS) begin
            cmd_in.op = OP_BACKSPACE;
        end else if (i_char_code == CODE_NL) begin
            cmd_in.op = OP_NEWLINE;
        end else begin
            cmd_in.op = OP_CHAR;
        end
    end

    assign o_full      = (r_cnt == NW'(DEPTH)) || i_status.clearing;
    assign accept      = i_push && !o_full;
    assign take        = i_status.take;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wp] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (accept) begin
                r_wp <= r_wp + 1'b1;
            end
            if (take) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + NW'(accept) - NW'(take);
        end
    end

endmodule

[sv/tcw_back.sv]
module tcw_back
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_attr_we,
    input  logic [BYTE_W-1:0]   i_attr,
    input  logic                i_cmd_valid,
    input  t_cmd                i_cmd,
    output t_back_status        o_status,
    output logic                o_empty,
    input  logic                i_pop,
    output t_result             o_result
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);

    localparam logic [AW-1:0] LAST_CELL      = AW'(CELLS - 1);
    localparam logic [AW-1:0] LAST_ROW_START = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0] COPY_END       = AW'(CELLS - COLUMNS - 1);
    localparam logic [AW-1:0] COL_STEP       = AW'(COLUMNS);
    localparam logic [CW-1:0] LAST_COL       = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] LAST_ROW       = RW'(ROWS - 1);

    t_state             r_state, n_state;
    logic [BYTE_W-1:0]  r_attr;
    logic [AW-1:0]      r_cursor, n_cursor;
    logic [RW-1:0]      r_row, n_row;
    logic [CW-1:0]      r_col, n_col;
    logic [AW-1:0]      r_addr, n_addr;
    logic [AW-1:0]      r_wa, n_wa;
    logic               r_pend, n_pend;
    logic [1:0]         r_step, n_step;
    logic               r_is_bs, n_is_bs;
    logic [BYTE_W-1:0]  r_res_byte, n_res_byte;
    logic               r_res_valid, n_res_valid;
    logic [CELL_W-1:0]  r_res_cell, n_res_cell;
    logic               r_rd_range, n_rd_range;

    logic [CELL_W-1:0]  r_mem [CELLS];
    logic [CELL_W-1:0]  r_rdata;
    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_wa, mem_ra;
    logic [CELL_W-1:0]  mem_wd;

    t_result            r_oq [2];
    logic               r_owp, r_orp;
    logic [1:0]         r_ocnt;
    logic               out_full;
    logic               out_push;
    logic               out_pop;
    t_result            res;

    logic               take;
    logic               last_col;
    logic               last_row;
    logic [AW-1:0]      bs_pos;

    assign last_col = (r_col == LAST_COL);
    assign last_row = (r_row == LAST_ROW);
    assign bs_pos   = (r_cursor == '0) ? '0 : r_cursor - 1'b1;
    assign out_full = (r_ocnt == 2'd2);
    assign out_pop  = i_pop && (r_ocnt != '0);
    assign o_empty  = (r_ocnt == '0);
    assign o_result = r_oq[r_orp];

    assign o_status.take     = take;
    assign o_status.clearing = (r_state == ST_CLEAR);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_addr == LAST_CELL) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.op)
                        OP_READ:      n_state = ST_READ;
                        OP_CHAR:      n_state = (last_col && last_row) ? ST_SCROLL : ST_EMIT;
                        OP_NEWLINE:   n_state = last_row ? ST_SCROLL : ST_EMIT;
                        OP_BACKSPACE: n_state = ST_EMIT;
                    endcase
                end
            end
            ST_READ: n_state = ST_EMIT;
            ST_SCROLL: begin
                if (r_addr == COPY_END) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_WIPE;
            ST_WIPE: begin
                if (r_addr == LAST_CELL) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!out_full && (!r_is_bs || r_step == STEP_LAST)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_cursor    = r_cursor;
        n_row       = r_row;
        n_col       = r_col;
        n_addr      = r_addr;
        n_wa        = r_wa;
        n_pend      = r_pend;
        n_step      = r_step;
        n_is_bs     = r_is_bs;
        n_res_byte  = r_res_byte;
        n_res_valid = r_res_valid;
        n_res_cell  = r_res_cell;
        n_rd_range  = r_rd_range;
        mem_we      = 1'b0;
        mem_wa      = r_addr;
        mem_wd      = '0;
        mem_re      = 1'b0;
        mem_ra      = r_addr;
        take        = 1'b0;
        out_push    = 1'b0;
        res.uart_byte       = r_is_bs ? ((r_step == STEP_SPACE) ? ECHO_SPACE : ECHO_BS)
                                      : r_res_byte;
        res.uart_valid      = r_res_valid;
        res.cursor_position = IDX_W'(r_cursor);
        res.cell_value      = r_res_cell;
        res.last            = !r_is_bs || (r_step == STEP_LAST);

        unique case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                n_addr = r_addr + 1'b1;
            end
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    take        = 1'b1;
                    n_is_bs     = 1'b0;
                    n_step      = '0;
                    n_res_valid = 1'b1;
                    n_res_cell  = '0;
                    n_addr      = '0;
                    n_pend      = 1'b0;
                    unique case (i_cmd.op)
                        OP_READ: begin
                            mem_re      = 1'b1;
                            mem_ra      = i_cmd.in_range ? AW'(i_cmd.read_index) : '0;
                            n_rd_range  = i_cmd.in_range;
                            n_res_valid = 1'b0;
                            n_res_byte  = '0;
                        end
                        OP_CHAR: begin
                            mem_we     = 1'b1;
                            mem_wa     = r_cursor;
                            mem_wd     = {r_attr, i_cmd.data};
                            n_res_byte = i_cmd.data;
                            if (last_col) begin
                                n_col = '0;
                                if (last_row) begin
                                    n_cursor = LAST_ROW_START;
                                end else begin
                                    n_row    = r_row + 1'b1;
                                    n_cursor = r_cursor + 1'b1;
                                end
                            end else begin
                                n_col    = r_col + 1'b1;
                                n_cursor = r_cursor + 1'b1;
                            end
                        end
                        OP_NEWLINE: begin
                            n_res_byte = ECHO_NL;
                            n_col      = '0;
                            if (last_row) begin
                                n_cursor = LAST_ROW_START;
                            end else begin
                                n_row    = r_row + 1'b1;
                                n_cursor = r_cursor + COL_STEP - AW'(r_col);
                            end
                        end
                        OP_BACKSPACE: begin
                            mem_we   = 1'b1;
                            mem_wa   = bs_pos;
                            mem_wd   = {r_attr, ECHO_SPACE};
                            n_is_bs  = 1'b1;
                            n_cursor = bs_pos;
                            if (r_cursor != '0) begin
                                if (r_col == '0) begin
                                    n_col = LAST_COL;
                                    n_row = r_row - 1'b1;
                                end else begin
                                    n_col = r_col - 1'b1;
                                end
                            end
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_res_cell = r_rd_range ? r_rdata : '0;
            end
            // copy one row up: read a row below, write the previous cell
            ST_SCROLL: begin
                mem_re = 1'b1;
                mem_ra = r_addr + COL_STEP;
                mem_we = r_pend;
                mem_wa = r_wa;
                mem_wd = r_rdata;
                n_wa   = r_addr;
                n_pend = 1'b1;
                n_addr = r_addr + 1'b1;
            end
            ST_DRAIN: begin
                mem_we = 1'b1;
                mem_wa = r_wa;
                mem_wd = r_rdata;
                n_addr = LAST_ROW_START;
            end
            ST_WIPE: begin
                mem_we = 1'b1;
                n_addr = r_addr + 1'b1;
            end
            ST_EMIT: begin
                out_push = !out_full;
                if (out_push && r_is_bs) begin
                    n_step = r_step + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_attr   <= ATTR_RESET;
            r_cursor <= '0;
            r_row    <= '0;
            r_col    <= '0;
            r_addr   <= '0;
            r_pend   <= 1'b0;
            r_step   <= '0;
            r_is_bs  <= 1'b0;
            r_owp    <= 1'b0;
            r_orp    <= 1'b0;
            r_ocnt   <= '0;
        end else begin
            r_state  <= n_state;
            if (i_attr_we) begin
                r_attr <= i_attr;
            end
            r_cursor <= n_cursor;
            r_row    <= n_row;
            r_col    <= n_col;
            r_addr   <= n_addr;
            r_pend   <= n_pend;
            r_step   <= n_step;
            r_is_bs  <= n_is_bs;
            if (out_push) begin
                r_owp <= ~r_owp;
            end
            if (out_pop) begin
                r_orp <= ~r_orp;
            end
            r_ocnt <= r_ocnt + 2'(out_push) - 2'(out_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        r_wa        <= n_wa;
        r_res_byte  <= n_res_byte;
        r_res_valid <= n_res_valid;
        r_res_cell  <= n_res_cell;
        r_rd_range  <= n_rd_range;
        if (out_push) begin
            r_oq[r_owp] <= res;
        end
    end

endmodule

[sv/text_console_writer.sv]
// Text-mode console writer with a ROWS x COLUMNS screen of 16-bit cells (attribute
// high, character low) held in one single-port-write, single-port-read memory.
// After reset a clearing pass writes ROWS*COLUMNS cells, one per cycle, and full
// stays high meanwhile; configuration writes are taken at any time. Items enter a
// four-deep command queue and results leave through a two-deep result queue. A
// printable code, newline or read gives one result and a backspace three echo
// results. When the cursor runs off the last row the screen scrolls: every cell
// is copied up one row and the last row blanked through the memory's single read
// and write ports.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_text_attribute_we,
    input  logic [BYTE_W-1:0]   i_text_attribute,
    input  logic                push,
    output logic                full,
    input  logic                i_mode,
    input  logic [CODE_W-1:0]   i_char_code,
    input  logic [IDX_W-1:0]    i_read_index,
    output logic                empty,
    input  logic                pop,
    output logic [BYTE_W-1:0]   o_uart_byte,
    output logic                o_uart_valid,
    output logic [IDX_W-1:0]    o_cursor_position,
    output logic [CELL_W-1:0]   o_cell_value,
    output logic                o_last
);

    logic           cmd_valid;
    t_cmd           cmd;
    t_back_status   status;
    t_result        result;

    tcw_front #(
        .CELLS (ROWS * COLUMNS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_mode       (i_mode),
        .i_char_code  (i_char_code),
        .i_read_index (i_read_index),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .i_status     (status)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_attr_we   (i_text_attribute_we),
        .i_attr      (i_text_attribute),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (result)
    );

    assign o_uart_byte       = result.uart_byte;
    assign o_uart_valid      = result.uart_valid;
    assign o_cursor_position = result.cursor_position;
    assign o_cell_value      = result.cell_value;
    assign o_last            = result.last;

endmodule

[sv/tcw_checker.sv]
module tcw_checker
    import tcw_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                full,
    input  logic                empty,
    input  logic                pop,
    input  logic [BYTE_W-1:0]   o_uart_byte,
    input  logic                o_uart_valid,
    input  logic [CELL_W-1:0]   o_cell_value,
    input  logic                o_last
);

    // clearing pass blocks input, no result left over
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> full && empty)
        else $error("full/empty wrong after reset");

    // read results carry no echo and end their item
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_uart_valid |-> o_uart_byte == '0 && o_last)
        else $error("read result malformed");

    a_put_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_uart_valid |-> o_cell_value == '0)
        else $error("put result carries a cell value");

    // backspace echo continues without a gap
    a_echo_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && pop && o_uart_valid && !o_last |=> !empty && o_uart_valid)
        else $error("echo sequence broken");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_uart_byte) && $stable(o_cell_value)
            && $stable(o_last))
        else $error("waiting result changed before transfer");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);

[dv/tb_text_console_writer.sv]
`timescale 1ns / 1ps

module tb_text_console_writer;
    import tcw_pkg::*;

    localparam int SCREEN_COLS = 80;
    localparam int SCREEN_ROWS = 24;
    localparam int CELLS       = SCREEN_COLS * SCREEN_ROWS;
    localparam int STALL_LIMIT = 20000;
    localparam logic MODE_PUT  = 1'b0;

    typedef struct packed {
        logic               mode;
        logic [CODE_W-1:0]  code;
        logic [IDX_W-1:0]   index;
    } t_console_item;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_text_attribute_we = 1'b0;
    logic [BYTE_W-1:0]   i_text_attribute = '0;
    logic                push = 1'b0;
    logic                full;
    logic                i_mode = 1'b0;
    logic [CODE_W-1:0]   i_char_code = '0;
    logic [IDX_W-1:0]    i_read_index = '0;
    logic                empty;
    logic                pop = 1'b0;
    logic [BYTE_W-1:0]   o_uart_byte;
    logic                o_uart_valid;
    logic [IDX_W-1:0]    o_cursor_position;
    logic [CELL_W-1:0]   o_cell_value;
    logic                o_last;

    t_console_item pending_items[$];
    t_result       awaited_results[$];
    t_console_item item_now;
    t_result       result_want;

    logic [CELL_W-1:0] screen_mem [CELLS];
    int unsigned       cursor_now;
    logic [BYTE_W-1:0] attr_now;

    int push_hold = 0;
    int push_run  = 0;
    int pop_hold  = 0;
    int pop_run   = 0;
    int fail_count = 0;
    int stim_count = 0;
    int idle_cycles = 0;

    text_console_writer #(
        .COLUMNS(SCREEN_COLS),
        .ROWS(SCREEN_ROWS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_text_attribute_we(i_text_attribute_we),
        .i_text_attribute(i_text_attribute),
        .push(push),
        .full(full),
        .i_mode(i_mode),
        .i_char_code(i_char_code),
        .i_read_index(i_read_index),
        .empty(empty),
        .pop(pop),
        .o_uart_byte(o_uart_byte),
        .o_uart_valid(o_uart_valid),
        .o_cursor_position(o_cursor_position),
        .o_cell_value(o_cell_value),
        .o_last(o_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int next_gap(inout int run_left);
        int r;
        if (run_left > 0) begin
            run_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            run_left = $urandom_range(10, 40);
            return 0;
        end
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // screen and cursor update for one accepted item, queues its expected results
    task automatic console_step(input t_console_item it);
        int unsigned pos;
        t_result r;
        r = '0;
        if (it.mode == MODE_READ) begin
            r.cursor_position = cursor_now[IDX_W-1:0];
            r.cell_value = (it.index < CELLS) ? screen_mem[it.index] : '0;
            r.last = 1'b1;
            awaited_results.push_back(r);
        end else begin
            pos = cursor_now;
            if (it.code == CODE_NL) begin
                pos += SCREEN_COLS - pos % SCREEN_COLS;
            end else if (it.code == CODE_BS) begin
                if (pos > 0) pos--;
            end else begin
                screen_mem[pos] = {attr_now, it.code[BYTE_W-1:0]};
                pos++;
            end
            if (pos / SCREEN_COLS >= SCREEN_ROWS) begin
                for (int i = 0; i < CELLS - SCREEN_COLS; i++)
                    screen_mem[i] = screen_mem[i + SCREEN_COLS];
                pos -= SCREEN_COLS;
                for (int i = pos; i < CELLS; i++)
                    screen_mem[i] = '0;
            end
            cursor_now = pos;
            r.uart_valid = 1'b1;
            r.cursor_position = pos[IDX_W-1:0];
            if (it.code == CODE_BS) begin
                screen_mem[pos] = {attr_now, ECHO_SPACE};
                r.uart_byte = ECHO_BS;
                awaited_results.push_back(r);
                r.uart_byte = ECHO_SPACE;
                awaited_results.push_back(r);
                r.uart_byte = ECHO_BS;
                r.last = 1'b1;
                awaited_results.push_back(r);
            end else begin
                r.uart_byte = it.code[BYTE_W-1:0];
                r.last = 1'b1;
                awaited_results.push_back(r);
            end
        end
    endtask

    // item driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
            push_hold = 0;
        end else if (!push || !full) begin
            if (push_hold > 0) begin
                push_hold--;
                push <= 1'b0;
            end else if (pending_items.size() != 0) begin
                item_now = pending_items.pop_front();
                push <= 1'b1;
                i_mode <= item_now.mode;
                i_char_code <= item_now.code;
                i_read_index <= item_now.index;
                push_hold = next_gap(push_run);
            end else begin
                push <= 1'b0;
            end
        end
    end

    // result receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
            pop_hold = 0;
        end else begin
            if (pop && !empty) pop_hold = next_gap(pop_run);
            if (pop_hold > 0) begin
                pop_hold--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // monitor: predicts on input transfers, checks on result transfers
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CELLS; i++) screen_mem[i] = '0;
            cursor_now = 0;
            attr_now = ATTR_RESET;
        end else begin
            if (pop && !empty) begin
                if (awaited_results.size() == 0) begin
                    $error("result transfer with nothing awaited");
                    fail_count++;
                end else begin
                    result_want = awaited_results.pop_front();
                    if (o_uart_byte !== result_want.uart_byte) begin
                        $error("uart_byte: expected %0h, got %0h",
                               result_want.uart_byte, o_uart_byte);
                        fail_count++;
                    end
                    if (o_uart_valid !== result_want.uart_valid) begin
                        $error("uart_valid: expected %0h, got %0h",
                               result_want.uart_valid, o_uart_valid);
                        fail_count++;
                    end
                    if (o_cursor_position !== result_want.cursor_position) begin
                        $error("cursor_position: expected %0d, got %0d",
                               result_want.cursor_position, o_cursor_position);
                        fail_count++;
                    end
                    if (o_cell_value !== result_want.cell_value) begin
                        $error("cell_value: expected %0h, got %0h",
                               result_want.cell_value, o_cell_value);
                        fail_count++;
                    end
                    if (o_last !== result_want.last) begin
                        $error("last: expected %0h, got %0h", result_want.last, o_last);
                        fail_count++;
                    end
                end
            end
            if (push && !full)
                console_step('{mode: i_mode, code: i_char_code, index: i_read_index});
            if (i_text_attribute_we) attr_now = i_text_attribute;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("text_console_writer: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic add_item(input logic mode, input logic [CODE_W-1:0] code,
                            input logic [IDX_W-1:0] index);
        pending_items.push_back('{mode: mode, code: code, index: index});
        stim_count++;
    endtask

    task automatic add_put(input logic [CODE_W-1:0] code);
        add_item(MODE_PUT, code, IDX_W'($urandom_range(0, 2047)));
    endtask

    task automatic add_read(input logic [IDX_W-1:0] index);
        add_item(MODE_READ, CODE_W'($urandom_range(0, 511)), index);
    endtask

    function automatic logic [IDX_W-1:0] pick_read_index();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return IDX_W'($urandom_range(CELLS, 2047));
        if (r < 50) return IDX_W'($urandom_range(CELLS - 2 * SCREEN_COLS, CELLS - 1));
        return IDX_W'($urandom_range(0, CELLS - 1));
    endfunction

    function automatic logic [CODE_W-1:0] pick_text_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return CODE_BS;
        if (r < 22) return CODE_W'($urandom_range(0, 511));
        return CODE_W'($urandom_range(32, 126));
    endfunction

    // lines of text with edits and read-back, newline bursts to reach the bottom, noise
    task automatic add_chunk(input int count);
        int start;
        int kind;
        int len;
        start = stim_count;
        while (stim_count - start < count) begin
            kind = $urandom_range(0, 99);
            if (kind < 65) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                                  : $urandom_range(0, 20);
                for (int i = 0; i < len; i++) add_put(pick_text_code());
                if ($urandom_range(0, 4) != 0) add_put(CODE_NL);
                repeat ($urandom_range(0, 2)) add_read(pick_read_index());
            end else if (kind < 75) begin
                repeat ($urandom_range(1, 25)) add_put(CODE_NL);
            end else begin
                add_item(1'($urandom_range(0, 1)), CODE_W'($urandom_range(0, 511)),
                         IDX_W'($urandom_range(0, 2047)));
            end
        end
    endtask

    task automatic wait_results_drained();
        while (pending_items.size() != 0 || push || awaited_results.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_attr(input logic [BYTE_W-1:0] value);
        @(posedge i_clk);
        i_text_attribute_we <= 1'b1;
        i_text_attribute <= value;
        @(posedge i_clk);
        i_text_attribute_we <= 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // cleared screen, backspace at home, code extremes, newline, backspace over a row
        add_read(11'd0);
        add_read(11'd1919);
        add_read(11'd2047);
        add_read(11'd1920);
        add_put(CODE_BS);
        add_put(9'h041);
        add_put(9'h1FF);
        add_put(9'h000);
        add_put(9'h10A);
        add_put(CODE_NL);
        add_put(CODE_BS);
        add_read(11'd0);
        add_read(11'd1);
        add_read(11'd2);
        add_read(11'd3);
        add_read(11'd79);
        wait_results_drained();

        write_attr(8'hFF);
        add_put(9'h155);
        add_put(9'h0AA);
        add_put(CODE_BS);
        add_read(11'd80);
        add_read(11'd81);
        add_read(11'd1919);
        wait_results_drained();

        for (int k = 0; k < 6; k++) begin
            if (k == 0) write_attr(8'h00);
            else if (k == 3) write_attr(8'hFF);
            else write_attr(BYTE_W'($urandom_range(1, 254)));
            add_chunk(50);
            wait_results_drained();
        end

        repeat (40) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("text_console_writer: match");
        end else begin
            $display("text_console_writer: mismatch");
        end
        $finish;
    end

endmodule
